### design/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

   // Network shape
   localparam int NUM_INPUTS      = 3;
   localparam int NUM_HIDDEN      = 6;
   localparam int NUM_CLASSES     = 2;
   localparam int FIELD_COUNT     = 3;
   localparam int SIGMOID_ENTRIES = 1024;
   localparam int SIG_HALF        = SIGMOID_ENTRIES / 2;
   localparam int IDX_W           = $clog2(SIGMOID_ENTRIES);

   // Field and datapath widths
   localparam int FEAT_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int PROB_W   = 16;
   localparam int OPA_W    = 17;                     // signed feature or zero-extended activation
   localparam int PROD_W   = OPA_W + WEIGHT_W;
   localparam int ACC_W    = 40;                     // holds s0 - s1 for up to 16 hidden units
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 40;

   // Lookup shifts: hidden sums carry 22 fraction bits, output sums 28; grid is 1/64
   localparam int SH_HID = 22 - 6;
   localparam int SH_OUT = 28 - 6;

   // Weight store layout: input weights row by row, then output weights row by row
   localparam int HID_TERMS    = NUM_INPUTS * NUM_HIDDEN;
   localparam int OUT_TERMS    = NUM_CLASSES * NUM_HIDDEN;
   localparam int WEIGHT_DEPTH = HID_TERMS + OUT_TERMS;
   localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);

   // Index widths
   localparam int X_IDX_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int ACT_IDX_W = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
   localparam int SEL_W     = (ACT_IDX_W > X_IDX_W) ? ACT_IDX_W : X_IDX_W;
   localparam int GRP_MAX   = (NUM_HIDDEN > NUM_CLASSES) ? NUM_HIDDEN : NUM_CLASSES;
   localparam int GRP_W     = $clog2(GRP_MAX);

   // Cycles from the last hidden product until its activation is stored
   localparam int DRAIN_CYC = 4;
   localparam int DRAIN_W   = $clog2(DRAIN_CYC);

   // exp(-1/64) in Q0.32
   localparam logic [63:0] STEP_EXP_Q32 = 64'd4228380001;

   typedef logic signed [WEIGHT_W-1:0] weight_rom_type [WEIGHT_DEPTH];
   typedef logic [PROB_W-1:0] sig_table_type [SIGMOID_ENTRIES];

   localparam weight_rom_type WEIGHT_ROM = '{
      -16'sd10093, -16'sd14340,  16'sd14488,
      -16'sd18977,  16'sd6607,   16'sd881,
      -16'sd3883,   16'sd4395,  -16'sd15266,
      -16'sd17371,  16'sd1356,  -16'sd74,
       16'sd3469,   16'sd17814, -16'sd12431,
       16'sd6050,   16'sd19366, -16'sd19362,
       16'sd15344,  16'sd16585,  16'sd15077, -16'sd8151,  16'sd16802,  16'sd4837,
      -16'sd16675, -16'sd5812,   16'sd10420, -16'sd16871, -16'sd10351, -16'sd15139
   };

   // Command from the sequencer to the datapath
   typedef struct packed {
      logic               x_load;
      logic               mul_en;
      logic               out_phase;
      logic [SEL_W-1:0]   sel;
      logic [GRP_W-1:0]   slot;
      logic [WADDR_W-1:0] waddr;
      logic               first;
      logic               last;
      logic               neg;
      logic               out_load;
   } msc_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic p0_done;
   } msc_status_type;

   // Build the sigmoid samples by the exponential recurrence, elaboration time only
   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   e;
      logic [63:0]   den;
      logic [63:0]   rem;
      logic [63:0]   p;
      logic [63:0]   pos;
      logic [63:0]   neg;
      int            n;
      int            b;
      e = 64'd1 << 32;
      for (n = 0; n <= SIG_HALF; n++) begin
         den = (64'd1 << 32) + e;
         rem = (64'd1 << 48) + (den >> 1);
         p   = '0;
         // shift-subtract quotient, result stays below 2^17
         for (b = 16; b >= 0; b--) begin
            if (rem >= (den << b)) begin
               rem = rem - (den << b);
               p   = p | (64'd1 << b);
            end
         end
         pos = (p > 64'd65535) ? 64'd65535 : p;
         neg = (p >= 64'd65536) ? 64'd0 : 64'd65536 - p;
         if (neg > 64'd65535) begin
            neg = 64'd65535;
         end
         if (SIG_HALF + n < SIGMOID_ENTRIES) begin
            tbl[SIG_HALF + n] = pos[PROB_W-1:0];
         end
         if (n > 0 && SIG_HALF - n >= 0) begin
            tbl[SIG_HALF - n] = neg[PROB_W-1:0];
         end
         e = (e * STEP_EXP_Q32 + (64'd1 << 31)) >> 32;
      end
      return tbl;
   endfunction

endpackage

### design/msc_ctrl.sv
`timescale 1ns / 1ps

module msc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output msc_pkg::msc_cmd_type    cmd,
   input  msc_pkg::msc_status_type st
);
   import msc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HID,
      ST_DRAIN,
      ST_OUT,
      ST_FINISH,
      ST_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic [WADDR_W-1:0] waddr_ff, waddr_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;
   logic [GRP_W-1:0]   grp_ff, grp_in;
   logic [DRAIN_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   // Drive datapath commands from the current state and counters
   always_comb begin
      cmd           = '0;
      cmd.x_load    = accept;
      cmd.mul_en    = (state_ff == ST_HID) || (state_ff == ST_OUT);
      cmd.out_phase = (state_ff == ST_OUT);
      cmd.sel       = sel_ff;
      cmd.slot      = grp_ff;
      cmd.waddr     = waddr_ff;
      if (state_ff == ST_OUT) begin
         cmd.first = (waddr_ff == WADDR_W'(HID_TERMS));
         cmd.last  = (waddr_ff == WADDR_W'(WEIGHT_DEPTH - 1));
         cmd.neg   = (grp_ff != '0);
      end else begin
         cmd.first = (sel_ff == '0);
         cmd.last  = (sel_ff == SEL_W'(NUM_INPUTS - 1));
         cmd.neg   = 1'b0;
      end
      cmd.out_load  = out_load;
   end

   // Sequence the hidden terms, the drain gap, the output terms and the result hand-off
   always_comb begin
      state_in     = state_ff;
      waddr_in     = waddr_ff;
      sel_in       = sel_ff;
      grp_in       = grp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HID;
               waddr_in = '0;
               sel_in   = '0;
               grp_in   = '0;
            end
         end
         ST_HID: begin
            waddr_in = waddr_ff + 1'b1;
            if (sel_ff == SEL_W'(NUM_INPUTS - 1)) begin
               sel_in = '0;
               if (grp_ff == GRP_W'(NUM_HIDDEN - 1)) begin
                  state_in = ST_DRAIN;
                  cnt_in   = '0;
               end else begin
                  grp_in = grp_ff + 1'b1;
               end
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DRAIN_W'(DRAIN_CYC - 1)) begin
               state_in = ST_OUT;
               sel_in   = '0;
               grp_in   = '0;
            end
         end
         ST_OUT: begin
            if (sel_ff == SEL_W'(NUM_HIDDEN - 1)) begin
               sel_in = '0;
               if (grp_ff == GRP_W'(NUM_CLASSES - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  grp_in   = grp_ff + 1'b1;
                  waddr_in = waddr_ff + 1'b1;
               end
            end else begin
               sel_in   = sel_ff + 1'b1;
               waddr_in = waddr_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (st.p0_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, counters and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         waddr_ff     <= '0;
         sel_ff       <= '0;
         grp_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waddr_ff     <= waddr_in;
         sel_ff       <= sel_in;
         grp_ff       <= grp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The probability must come back while the sequencer waits for it
   a_done_in_finish: assert property (@(posedge clock) disable iff (reset)
      st.p0_done |-> (state_ff == ST_FINISH))
      else $error("probability ready outside finish state");

   // An accepted item starts at the first input weight
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HID) && (waddr_ff == '0))
      else $error("accepted item did not start hidden phase");

   // Output weights follow the input weights directly
   a_drain_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (waddr_ff == WADDR_W'(HID_TERMS)))
      else $error("weight address off at end of hidden phase");

endmodule

### design/msc_datapath.sv
`timescale 1ns / 1ps

module msc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [15:0]       feature_a,
   input  logic signed [15:0]       feature_b,
   input  logic signed [15:0]       feature_c,
   input  msc_pkg::msc_cmd_type     cmd,
   output msc_pkg::msc_status_type  st,
   output logic [15:0]              prob_class_zero,
   output logic [15:0]              prob_class_one,
   output logic                     winner
);
   import msc_pkg::*;

   // Sigmoid samples, read one entry a cycle with registered data
   localparam sig_table_type SIG_ROM = build_sig_table();

   logic signed [FEAT_W-1:0]   x_ff [NUM_INPUTS];
   logic [PROB_W-1:0]          act_ff [NUM_HIDDEN];

   logic signed [OPA_W-1:0]    opa;
   logic signed [WEIGHT_W-1:0] wgt;
   logic signed [PROD_W-1:0]   prod_in;

   // multiply stage
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       pv_ff, pf_ff, pl_ff, pn_ff, pk_ff;
   logic [GRP_W-1:0]           ps_ff;

   // accumulate stage
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    prod_ext;
   logic                       sum_vld_ff, sum_kind_ff;
   logic [GRP_W-1:0]           sum_slot_ff;

   // index stage
   logic signed [ACC_W-1:0]    shifted;
   logic signed [ACC_W-1:0]    biased;
   logic [IDX_W-1:0]           idx_in;
   logic [IDX_W-1:0]           idx_ff;
   logic                       idx_vld_ff, idx_kind_ff;
   logic [GRP_W-1:0]           idx_slot_ff;

   // table read stage
   logic [PROB_W-1:0]          rom_ff;
   logic                       rom_vld_ff, rom_kind_ff;
   logic [GRP_W-1:0]           rom_slot_ff;

   // probability and result registers
   logic [PROB_W-1:0]          p0_ff;
   logic                       p0_done_ff;
   logic [PROB_W-1:0]          p1_in;
   logic [PROB_W-1:0]          out_p0_ff, out_p1_ff;
   logic                       out_win_ff;

   // Latch features; inputs past the field count read as zero
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_INPUTS; k++) begin
         if (cmd.x_load) begin
            if (k == 0) begin
               x_ff[k] <= feature_a;
            end else if (k == 1) begin
               x_ff[k] <= feature_b;
            end else if (k == 2) begin
               x_ff[k] <= feature_c;
            end else begin
               x_ff[k] <= '0;
            end
         end
      end
   end

   // Select operands and multiply
   always_comb begin
      if (cmd.out_phase) begin
         opa = $signed({1'b0, act_ff[cmd.sel[ACT_IDX_W-1:0]]});
      end else begin
         opa = $signed({x_ff[cmd.sel[X_IDX_W-1:0]][FEAT_W-1],
                        x_ff[cmd.sel[X_IDX_W-1:0]]});
      end
      wgt     = WEIGHT_ROM[cmd.waddr];
      prod_in = opa * wgt;
   end

   // Accumulate; class one terms are subtracted so the sum is s0 - s1
   always_comb begin
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      acc_in   = acc_ff;
      if (pv_ff) begin
         if (pn_ff) begin
            acc_in = (pf_ff ? '0 : acc_ff) - prod_ext;
         end else begin
            acc_in = (pf_ff ? '0 : acc_ff) + prod_ext;
         end
      end
   end

   // Map the sum onto the 1/64 grid and clamp to the table ends
   always_comb begin
      shifted = sum_kind_ff ? (acc_ff >>> SH_OUT) : (acc_ff >>> SH_HID);
      biased  = shifted + ACC_W'(SIG_HALF);
      if (biased[ACC_W-1]) begin
         idx_in = '0;
      end else if (biased > ACC_W'(SIGMOID_ENTRIES - 1)) begin
         idx_in = IDX_W'(SIGMOID_ENTRIES - 1);
      end else begin
         idx_in = biased[IDX_W-1:0];
      end
   end

   // Payload registers of the pipeline
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      pf_ff       <= cmd.first;
      pl_ff       <= cmd.last;
      pn_ff       <= cmd.neg;
      pk_ff       <= cmd.out_phase;
      ps_ff       <= cmd.slot;
      acc_ff      <= acc_in;
      sum_kind_ff <= pk_ff;
      sum_slot_ff <= ps_ff;
      idx_ff      <= idx_in;
      idx_kind_ff <= sum_kind_ff;
      idx_slot_ff <= sum_slot_ff;
      rom_ff      <= SIG_ROM[idx_ff];
      rom_kind_ff <= idx_kind_ff;
      rom_slot_ff <= idx_slot_ff;
      if (rom_vld_ff && !rom_kind_ff) begin
         act_ff[rom_slot_ff[ACT_IDX_W-1:0]] <= rom_ff;
      end
      if (rom_vld_ff && rom_kind_ff) begin
         p0_ff <= rom_ff;
      end
   end

   // Advance the valid flags of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff      <= 1'b0;
         sum_vld_ff <= 1'b0;
         idx_vld_ff <= 1'b0;
         rom_vld_ff <= 1'b0;
         p0_done_ff <= 1'b0;
      end else begin
         pv_ff      <= cmd.mul_en;
         sum_vld_ff <= pv_ff && pl_ff;
         idx_vld_ff <= sum_vld_ff;
         rom_vld_ff <= idx_vld_ff;
         p0_done_ff <= rom_vld_ff && rom_kind_ff;
      end
   end

   // P1 = 1 - P0, saturated when P0 is zero
   assign p1_in = (p0_ff == '0) ? '1 : PROB_W'(~p0_ff + 1'b1);

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_p0_ff  <= p0_ff;
         out_p1_ff  <= p1_in;
         out_win_ff <= (p1_in > p0_ff);
      end
   end

   assign st.p0_done      = p0_done_ff;
   assign prob_class_zero = out_p0_ff;
   assign prob_class_one  = out_p1_ff;
   assign winner          = out_win_ff;

   // Activations only go to existing hidden slots
   a_act_slot: assert property (@(posedge clock) disable iff (reset)
      (rom_vld_ff && !rom_kind_ff) |-> (rom_slot_ff < GRP_W'(NUM_HIDDEN)))
      else $error("activation written past last hidden unit");

endmodule

### design/mlp_sigmoid_softmax_classifier_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents (lowest bits first)
// req_*     in   48     feature_a[15:0], feature_b[31:16], feature_c[47:32], signed Q5.10
// rsp_*     out  40     prob_class_zero[15:0], prob_class_one[31:16], winner[32], zero pad
//
// One item at a time, from acceptance until its result is loaded: 30 weight terms
// through one shared multiplier and accumulator, a drain gap for the last hidden
// activation, and a 5-stage table lookup pipeline into a 1024-entry sigmoid ROM.
// Synchronous active-high reset clears the sequencer and pipeline valid flags only.
// A new item is taken while a result waits in the output register; a stalled result
// only delays the hand-off of the following one.

module mlp_sigmoid_softmax_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // feature_a, feature_b, feature_c
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // prob_class_zero, prob_class_one, winner, pad
);
   import msc_pkg::*;

   msc_cmd_type    cmd;
   msc_status_type st;
   logic [15:0]    prob_class_zero;
   logic [15:0]    prob_class_one;
   logic           winner;

   msc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .st         (st)
   );

   msc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .feature_a       ($signed(req_tdata[15:0])),
      .feature_b       ($signed(req_tdata[31:16])),
      .feature_c       ($signed(req_tdata[47:32])),
      .cmd             (cmd),
      .st              (st),
      .prob_class_zero (prob_class_zero),
      .prob_class_one  (prob_class_one),
      .winner          (winner)
   );

   // Pack the result item
   assign rsp_tdata = {(RSP_W - 33)'(0), winner, prob_class_one, prob_class_zero};

endmodule
